// ===== design/mnsp_pkg.sv =====
// shared constants, types and key color map for the midi note stream parser
package mnsp_pkg;

  localparam int unsigned KEY_COUNT = 88;

  localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] NOTE_BASE    = 8'h14;
  localparam logic [7:0] NOTE_ON_CMD  = 8'h90;
  localparam logic [7:0] NOTE_OFF_CMD = 8'h80;
  localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;
  localparam logic [7:0] LEVEL_FULL   = 8'hFF;

  localparam logic EVENT_COLOR = 1'b0;
  localparam logic EVENT_NOTE  = 1'b1;

  typedef struct packed {
    logic       expect_note;
    logic       expect_velocity;
    logic       note_is_on;
    logic [7:0] running_status;
    logic [7:0] held_note;
  } state_t;

  typedef struct packed {
    logic       event_kind;
    logic       note_on;
    logic [7:0] note_number;
    logic [7:0] color_index;
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
  } result_t;

  // white key flag for every palette slot; slot minus one is the key position
  function automatic logic [255:0] white_map_build();
    logic [255:0] map;
    int           pos;
    int           p;
    map = '0;
    for (int i = 0; i < 256; i++) begin
      pos = i - 1;
      if (pos < 0 || pos >= int'(KEY_COUNT)) begin
        map[i] = 1'b0;
      end else if (pos < 3) begin
        map[i] = (pos != 1);
      end else begin
        p = (pos - 3) % 12;
        map[i] = (p == 0 || p == 2 || p == 4 || p == 5 || p == 7 || p == 9 || p == 11);
      end
    end
    return map;
  endfunction

  localparam logic [255:0] WHITE_MAP = white_map_build();

endpackage

// ===== design/mnsp_in_if.sv =====
// input byte channel
interface mnsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/mnsp_out_if.sv =====
// result event channel
interface mnsp_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic       note_on;
  logic [7:0] note_number;
  logic [7:0] color_index;
  logic [7:0] color_red;
  logic [7:0] color_green;
  logic [7:0] color_blue;

  modport source (output valid, output event_kind, output note_on, output note_number,
                  output color_index, output color_red, output color_green,
                  output color_blue, input ready);
  modport sink (input valid, input event_kind, input note_on, input note_number,
                input color_index, input color_red, input color_green,
                input color_blue, output ready);
endinterface

// ===== design/mnsp_decode.sv =====
// combinational byte decoder: next parser state and optional event
module mnsp_decode (
  input  logic [7:0]       rx_byte,
  input  mnsp_pkg::state_t state,
  output mnsp_pkg::state_t state_nxt,
  output logic             has_result,
  output mnsp_pkg::result_t result
);

  logic [7:0] idx;
  logic       white;
  logic [7:0] lvl;

  assign idx   = rx_byte - mnsp_pkg::NOTE_BASE;
  assign white = mnsp_pkg::WHITE_MAP[idx];
  assign lvl   = white ? mnsp_pkg::LEVEL_FULL : 8'h00;

  always_comb begin
    state_nxt  = state;
    has_result = 1'b0;
    result     = '0;
    if (rx_byte == mnsp_pkg::ACTIVE_SENSE) begin
      // active sense, dropped
    end else if (state.expect_velocity) begin
      // velocity value ignored, completes the note event
      state_nxt.expect_velocity = 1'b0;
      has_result                = 1'b1;
      result.event_kind         = mnsp_pkg::EVENT_NOTE;
      result.note_on            = state.note_is_on;
      result.note_number        = state.held_note;
    end else if (state.expect_note) begin
      has_result         = 1'b1;
      result.event_kind  = mnsp_pkg::EVENT_COLOR;
      result.note_on     = state.note_is_on;
      result.note_number = rx_byte;
      result.color_index = idx;
      if (state.note_is_on) begin
        result.color_red   = mnsp_pkg::LEVEL_FULL;
        result.color_green = 8'h00;
        result.color_blue  = mnsp_pkg::LEVEL_FULL;
      end else begin
        result.color_red   = lvl;
        result.color_green = lvl;
        result.color_blue  = lvl;
      end
      state_nxt.expect_note     = 1'b0;
      state_nxt.held_note       = rx_byte;
      state_nxt.expect_velocity = 1'b1;
    end else if ((rx_byte & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_ON_CMD) begin
      state_nxt.expect_note    = 1'b1;
      state_nxt.note_is_on     = 1'b1;
      state_nxt.running_status = rx_byte;
    end else if ((rx_byte & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_OFF_CMD) begin
      state_nxt.expect_note    = 1'b1;
      state_nxt.note_is_on     = 1'b0;
      state_nxt.running_status = rx_byte;
    end else if (!rx_byte[7]) begin
      // running status: data byte becomes the held note
      state_nxt.held_note       = rx_byte;
      state_nxt.expect_velocity = 1'b1;
      if ((state.running_status & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_ON_CMD) begin
        state_nxt.note_is_on = 1'b1;
      end else if ((state.running_status & mnsp_pkg::HIGH_NIBBLE) ==
                   mnsp_pkg::NOTE_OFF_CMD) begin
        state_nxt.note_is_on = 1'b0;
      end
    end
  end

endmodule

// ===== design/midi_note_stream_parser_unit.sv =====
// midi note on/off stream parser with key color events, top level
// an accepted byte beat goes to the input byte register, and its event then to
//   the event register; throughput: one byte beat per cycle while the event
//   register is empty or drains, via the single decode stage between the two
// reset: synchronous active-low rst_n empties both stages and restores the
//   parser state (running status 0x90, note capture idle)
module midi_note_stream_parser_unit (
  input  logic      clk,
  input  logic      rst_n,
  mnsp_in_if.sink   in_bus,
  mnsp_out_if.source out_bus
);

  // input byte stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // parser state, updated when the staged byte is decoded
  mnsp_pkg::state_t state_r;
  mnsp_pkg::state_t state_nxt;

  // event register
  logic              out_valid_r;
  mnsp_pkg::result_t out_res_r;

  logic              dec_has_result;
  mnsp_pkg::result_t dec_result;

  // the decode stage moves whenever the event register is empty or drains
  logic advance;
  logic in_ready;

  assign advance  = !out_valid_r || out_bus.ready;
  assign in_ready = !s1_valid_r || advance;

  assign in_bus.ready = in_ready;

  mnsp_decode u_decode (
    .rx_byte    (s1_byte_r),
    .state      (state_r),
    .state_nxt  (state_nxt),
    .has_result (dec_has_result),
    .result     (dec_result)
  );

  // byte staging
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_bus.valid) begin
      s1_byte_r <= in_bus.rx_byte;
    end
  end

  // parser state commits only when a staged byte is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.expect_note     <= 1'b0;
      state_r.expect_velocity <= 1'b0;
      state_r.note_is_on      <= 1'b0;
      state_r.running_status  <= mnsp_pkg::NOTE_ON_CMD;
      state_r.held_note       <= 8'h00;
    end else if (advance && s1_valid_r) begin
      state_r <= state_nxt;
    end
  end

  // event register: bytes that give no event leave it empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && dec_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= dec_result;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.event_kind  = out_res_r.event_kind;
  assign out_bus.note_on     = out_res_r.note_on;
  assign out_bus.note_number = out_res_r.note_number;
  assign out_bus.color_index = out_res_r.color_index;
  assign out_bus.color_red   = out_res_r.color_red;
  assign out_bus.color_green = out_res_r.color_green;
  assign out_bus.color_blue  = out_res_r.color_blue;

endmodule

// ===== sim/tb_midi_note_stream_parser_unit.sv =====
// self-checking testbench for the midi note stream parser, directed table then random bytes
module tb_midi_note_stream_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 400;
  // white keys inside one octave, bit n set for white at octave offset n
  localparam logic [11:0] OCTAVE_WHITE = 12'hAB5;

  // how a directed row gets its expected event
  typedef enum logic [1:0] {ROW_QUIET, ROW_TYPED, ROW_PREDICT} row_mode_t;

  typedef struct {
    logic [7:0]        rx_byte;
    row_mode_t         mode;
    mnsp_pkg::result_t typed;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mnsp_in_if  in_ch ();
  mnsp_out_if out_ch ();

  midi_note_stream_parser_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  // parser state as seen by the predictor
  logic       pr_expect_note;
  logic       pr_expect_vel;
  logic       pr_on;
  logic [7:0] pr_status;
  logic [7:0] pr_held;

  mnsp_pkg::result_t pending_events[$];
  stim_row_t         directed_rows[$];

  int error_count;
  int beat_count;
  int color_seen;
  int note_seen;
  int cycle_count;
  int idle_pct;
  int stall_pct;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count <= cycle_count + 1;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d events still pending", cycle_count,
             pending_events.size());
    $display("Regression FAIL");
    $finish;
  end

  // key color lookup, position is palette slot minus one
  function automatic bit key_white(int pos);
    if (pos < 0 || pos >= int'(mnsp_pkg::KEY_COUNT)) begin
      return 1'b0;
    end
    if (pos < 3) begin
      return pos != 1;
    end
    return OCTAVE_WHITE[(pos - 3) % 12];
  endfunction

  // advance the parser state by one byte and say what event it raises
  task automatic parse_byte(input logic [7:0] b, output bit has_event,
                            output mnsp_pkg::result_t ev);
    logic [7:0] slot;
    logic [7:0] lvl;
    has_event = 1'b0;
    ev = '0;
    slot = b - mnsp_pkg::NOTE_BASE;
    if (b == mnsp_pkg::ACTIVE_SENSE) begin
      // dropped in every state
    end else if (pr_expect_vel) begin
      // any byte fills the velocity slot, status bytes too
      pr_expect_vel   = 1'b0;
      has_event       = 1'b1;
      ev.event_kind   = mnsp_pkg::EVENT_NOTE;
      ev.note_on      = pr_on;
      ev.note_number  = pr_held;
    end else if (pr_expect_note) begin
      has_event       = 1'b1;
      ev.event_kind   = mnsp_pkg::EVENT_COLOR;
      ev.note_on      = pr_on;
      ev.note_number  = b;
      ev.color_index  = slot;
      if (pr_on) begin
        // magenta for a key going down
        ev.color_red   = mnsp_pkg::LEVEL_FULL;
        ev.color_green = 8'h00;
        ev.color_blue  = mnsp_pkg::LEVEL_FULL;
      end else begin
        lvl = key_white(int'(slot) - 1) ? mnsp_pkg::LEVEL_FULL : 8'h00;
        ev.color_red   = lvl;
        ev.color_green = lvl;
        ev.color_blue  = lvl;
      end
      pr_expect_note = 1'b0;
      pr_held        = b;
      pr_expect_vel  = 1'b1;
    end else if ((b & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_ON_CMD) begin
      pr_expect_note = 1'b1;
      pr_on          = 1'b1;
      pr_status      = b;
    end else if ((b & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_OFF_CMD) begin
      pr_expect_note = 1'b1;
      pr_on          = 1'b0;
      pr_status      = b;
    end else if (b < 8'h80) begin
      // running status: data byte becomes the note, flag follows the last status
      pr_held       = b;
      pr_expect_vel = 1'b1;
      if ((pr_status & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_ON_CMD) begin
        pr_on = 1'b1;
      end else if ((pr_status & mnsp_pkg::HIGH_NIBBLE) == mnsp_pkg::NOTE_OFF_CMD) begin
        pr_on = 1'b0;
      end
    end
    // remaining statuses are ignored and keep running status
  endtask

  function automatic mnsp_pkg::result_t note_ev(logic on, logic [7:0] note);
    mnsp_pkg::result_t r;
    r = '0;
    r.event_kind  = mnsp_pkg::EVENT_NOTE;
    r.note_on     = on;
    r.note_number = note;
    return r;
  endfunction

  function automatic mnsp_pkg::result_t color_ev(logic on, logic [7:0] note,
                                                 logic [7:0] slot, logic [7:0] red,
                                                 logic [7:0] green, logic [7:0] blue);
    mnsp_pkg::result_t r;
    r.event_kind  = mnsp_pkg::EVENT_COLOR;
    r.note_on     = on;
    r.note_number = note;
    r.color_index = slot;
    r.color_red   = red;
    r.color_green = green;
    r.color_blue  = blue;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] b, input row_mode_t mode,
                         input mnsp_pkg::result_t typed);
    stim_row_t row;
    row.rx_byte = b;
    row.mode    = mode;
    row.typed   = typed;
    directed_rows.push_back(row);
  endtask

  // drive one byte beat, with random idle cycles ahead of it, then log what it should raise
  task automatic send_beat(input logic [7:0] b, input row_mode_t mode,
                           input mnsp_pkg::result_t typed);
    bit                has_event;
    mnsp_pkg::result_t ev;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // accepted at this edge
    beat_count++;
    parse_byte(b, has_event, ev);
    if (mode == ROW_TYPED) begin
      pending_events.push_back(typed);
    end else if (mode == ROW_PREDICT && has_event) begin
      pending_events.push_back(ev);
    end
  endtask

  // hold the sender off until the parser has drained every expected event
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
    end
  endtask

  // result side: random backpressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker, every accepted event against the oldest expectation
  always @(posedge clk) begin
    mnsp_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        error_count++;
        $error("event with nothing expected: kind %0d note 'h%0h", out_ch.event_kind,
               out_ch.note_number);
      end else begin
        want = pending_events.pop_front();
        if (want.event_kind == mnsp_pkg::EVENT_NOTE) note_seen++;
        else color_seen++;
        check_field("event_kind", 8'(want.event_kind), 8'(out_ch.event_kind));
        check_field("note_on", 8'(want.note_on), 8'(out_ch.note_on));
        check_field("note_number", want.note_number, out_ch.note_number);
        check_field("color_index", want.color_index, out_ch.color_index);
        check_field("color_red", want.color_red, out_ch.color_red);
        check_field("color_green", want.color_green, out_ch.color_green);
        check_field("color_blue", want.color_blue, out_ch.color_blue);
      end
    end
  end

  // stimulus
  initial begin
    int         sent;
    int         pick;
    logic [7:0] b;
    error_count = 0;
    beat_count  = 0;
    color_seen  = 0;
    note_seen   = 0;
    idle_pct    = 13;
    stall_pct   = 13;
    // predictor starts from the reset state
    pr_expect_note = 1'b0;
    pr_expect_vel  = 1'b0;
    pr_on          = 1'b0;
    pr_status      = mnsp_pkg::NOTE_ON_CMD;
    pr_held        = 8'h00;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    // running status straight out of reset is note on
    add_row(8'h3C, ROW_QUIET, '0);
    add_row(8'h40, ROW_TYPED, note_ev(1'b1, 8'h3C));
    // active sense while idle, while waiting for the note and for the velocity
    add_row(mnsp_pkg::ACTIVE_SENSE, ROW_QUIET, '0);
    add_row(mnsp_pkg::NOTE_OFF_CMD, ROW_QUIET, '0);
    add_row(mnsp_pkg::ACTIVE_SENSE, ROW_QUIET, '0);
    // lowest key, white
    add_row(8'h15, ROW_TYPED, color_ev(1'b0, 8'h15, 8'h01, mnsp_pkg::LEVEL_FULL,
                                       mnsp_pkg::LEVEL_FULL, mnsp_pkg::LEVEL_FULL));
    add_row(mnsp_pkg::ACTIVE_SENSE, ROW_QUIET, '0);
    // a status byte in the velocity slot is just the velocity
    add_row(mnsp_pkg::NOTE_ON_CMD, ROW_TYPED, note_ev(1'b0, 8'h15));
    add_row(mnsp_pkg::NOTE_OFF_CMD | 8'h05, ROW_QUIET, '0);
    // second key, black
    add_row(8'h16, ROW_TYPED, color_ev(1'b0, 8'h16, 8'h02, 8'h00, 8'h00, 8'h00));
    add_row(8'h00, ROW_TYPED, note_ev(1'b0, 8'h16));
    // other status ignored, running status stays note off
    add_row(8'hA3, ROW_QUIET, '0);
    add_row(8'h30, ROW_QUIET, '0);
    add_row(8'h7F, ROW_TYPED, note_ev(1'b0, 8'h30));
    // note on with the slot wrapping below zero
    add_row(mnsp_pkg::NOTE_ON_CMD | 8'h0F, ROW_QUIET, '0);
    add_row(8'h00, ROW_TYPED, color_ev(1'b1, 8'h00, 8'hEC, mnsp_pkg::LEVEL_FULL, 8'h00,
                                       mnsp_pkg::LEVEL_FULL));
    add_row(8'hFF, ROW_TYPED, note_ev(1'b1, 8'h00));
    add_row(8'hFF, ROW_QUIET, '0);
    // slot zero sits below the keyboard, black
    add_row(mnsp_pkg::NOTE_OFF_CMD | 8'h0F, ROW_QUIET, '0);
    add_row(8'h14, ROW_TYPED, color_ev(1'b0, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(mnsp_pkg::NOTE_OFF_CMD, ROW_TYPED, note_ev(1'b0, 8'h14));
    // top key, white
    add_row(mnsp_pkg::NOTE_OFF_CMD, ROW_QUIET, '0);
    add_row(8'h6C, ROW_TYPED, color_ev(1'b0, 8'h6C, 8'h58, mnsp_pkg::LEVEL_FULL,
                                       mnsp_pkg::LEVEL_FULL, mnsp_pkg::LEVEL_FULL));
    add_row(8'h55, ROW_TYPED, note_ev(1'b0, 8'h6C));
    // one past the keyboard
    add_row(mnsp_pkg::NOTE_OFF_CMD | 8'h0A, ROW_QUIET, '0);
    add_row(8'h6D, ROW_PREDICT, '0);
    add_row(8'h01, ROW_PREDICT, '0);
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].rx_byte, directed_rows[i].mode, directed_rows[i].typed);
    end
    drain_events();

    // random part: mostly well-formed messages with random content, some noise
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      // a stretch with no idling on either side
      if (sent >= 150 && sent < 250) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 13;
        stall_pct = 13;
      end
      if (sent >= 300 && sent < 304) begin
        drain_events();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // status, note, velocity
        b = ($urandom_range(0, 1) ? mnsp_pkg::NOTE_ON_CMD : mnsp_pkg::NOTE_OFF_CMD) |
            8'($urandom_range(0, 15));
        send_beat(b, ROW_PREDICT, '0);
        sent++;
        if ($urandom_range(0, 99) < 8) send_beat(mnsp_pkg::ACTIVE_SENSE, ROW_PREDICT, '0);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          b = 8'($urandom_range(mnsp_pkg::NOTE_BASE,
                                mnsp_pkg::NOTE_BASE + mnsp_pkg::KEY_COUNT + 2));
        end else if (pick < 90) begin
          b = 8'($urandom_range(0, 127));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_beat(b, ROW_PREDICT, '0);
        sent++;
        if ($urandom_range(0, 99) < 8) send_beat(mnsp_pkg::ACTIVE_SENSE, ROW_PREDICT, '0);
        b = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
        send_beat(b, ROW_PREDICT, '0);
        sent++;
      end else if (pick < 75) begin
        // running status pair
        send_beat(8'($urandom_range(0, 127)), ROW_PREDICT, '0);
        send_beat(8'($urandom_range(0, 255)), ROW_PREDICT, '0);
        sent += 2;
      end else begin
        // noise, may break a message in progress
        b = 8'($urandom_range(0, 255));
        send_beat(b, ROW_PREDICT, '0);
        if (b != mnsp_pkg::ACTIVE_SENSE) sent++;
      end
    end

    // wait for the tail, then a few cycles for anything stray
    idle_pct = 13;
    drain_events();
    repeat (8) @(posedge clk);

    $display("ran %0d byte beats (directed table and random messages with noise)", beat_count);
    $display("checked %0d key color events and %0d note events", color_seen, note_seen);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mnsp_pkg.sv
design/mnsp_in_if.sv
design/mnsp_out_if.sv
design/mnsp_decode.sv
design/midi_note_stream_parser_unit.sv
sim/tb_midi_note_stream_parser_unit.sv
